@@ src/dmlb_pkg.sv @@
package dmlb_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_DARK_THR = 3'd1;
	localparam logic [2:0] REG_WINDOW   = 3'd2;
	localparam logic [2:0] REG_SLOW     = 3'd3;
	localparam logic [2:0] REG_MEDIUM   = 3'd4;
	localparam logic [2:0] REG_FAST     = 3'd5;

	// Register reset values
	localparam logic [15:0] RST_DEBOUNCE = 16'd50;
	localparam logic [10:0] RST_DARK_THR = 11'd50;
	localparam logic [15:0] RST_WINDOW   = 16'd5000;
	localparam logic [15:0] RST_SLOW     = 16'd1000;
	localparam logic [15:0] RST_MEDIUM   = 16'd500;
	localparam logic [15:0] RST_FAST     = 16'd200;

	// Reset value of the light mean
	localparam int MEAN_RESET = 1000;

	// Mode codes
	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_STEADY = 3'd1;
	localparam logic [2:0] MODE_SLOW   = 3'd2;
	localparam logic [2:0] MODE_MEDIUM = 3'd3;
	localparam logic [2:0] MODE_FAST   = 3'd4;
	localparam logic [2:0] MODE_ALT    = 3'd5;
	localparam logic [2:0] MODE_MAX    = 3'd7;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the input transfer
		logic deb;    // sample append, debounce, mode step
		logic blk;    // blink timing, window check, divider start
		logic div;    // one divider iteration
		logic set;    // mean update and LED pins
		logic pub;    // load the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic win_due;   // window expired: recompute mean
		logic div_last;  // divider runs its last iteration
	} stat_t;

endpackage

@@ src/dmlb_ctrl.sv @@
module dmlb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dmlb_pkg::stat_t stat,
	output dmlb_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEB  = 3'd1;
	localparam logic [2:0] ST_BLK  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_SET  = 3'd4;
	localparam logic [2:0] ST_PUB  = 3'd5;

	logic [2:0] state_q, state_nx;
	logic       out_valid_q;
	logic       pub_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pub_go    = (state_q == ST_PUB) && (!out_valid_q || out_ready);

	// Decode commands and next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DEB;
				end
			end
			ST_DEB: begin
				cmd.deb  = 1'b1;
				state_nx = ST_BLK;
			end
			ST_BLK: begin
				cmd.blk  = 1'b1;
				state_nx = stat.win_due ? ST_DIV : ST_SET;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_last) state_nx = ST_SET;
			end
			ST_SET: begin
				cmd.set  = 1'b1;
				state_nx = ST_PUB;
			end
			ST_PUB: begin
				if (pub_go) begin
					cmd.pub  = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Advance state and hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (pub_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/dmlb_dp.sv @@
module dmlb_dp #(
	parameter int SAMPLE_SLOTS = 5,
	parameter int LIGHT_BITS   = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmlb_pkg::cmd_t        cmd,
	output dmlb_pkg::stat_t       stat,
	input  logic                  cfg_valid,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  button_level,
	input  logic [LIGHT_BITS-1:0] light_sample,
	input  logic [31:0]           now_ms,
	output logic                  led_one,
	output logic                  led_two,
	output logic [2:0]            mode_now
);

	localparam int CW = $clog2(SAMPLE_SLOTS + 1);
	localparam int SW = LIGHT_BITS + CW;
	localparam int KW = $clog2(SW);
	localparam int MW = (LIGHT_BITS > 10) ? LIGHT_BITS : 10;
	localparam int TW = (MW > 11) ? MW : 11;

	// Configuration registers
	logic [15:0] deb_ms_q, win_ms_q, slow_q, med_q, fast_q;
	logic [10:0] thr_q;

	// Captured input item
	logic                  lvl_q;
	logic [LIGHT_BITS-1:0] smp_q;
	logic [31:0]           now_q;

	// Controller state of the block
	logic          last_q, stab_q, phase_q, pin1_q, pin2_q, tog_q, pend_q;
	logic [2:0]    mode_q;
	logic [31:0]   chg_q, blk_q, win_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mean_q;

	// Divider
	logic [SW-1:0] dvd_q;
	logic [CW-1:0] dvs_q, rem_q;
	logic [KW-1:0] k_q;

	// Output register
	logic       o_led1_q, o_led2_q;
	logic [2:0] o_mode_q;

	logic [31:0]   ct_nx, deb_el, blk_el, win_el;
	logic [15:0]   ivl;
	logic          blinking, due, win_chk;
	logic [CW:0]   trial, trial_sub;
	logic          q_bit;
	logic [MW-1:0] mean_nx;
	logic          dark;

	// Debounce timing
	assign ct_nx  = (lvl_q != last_q) ? now_q : chg_q;
	assign deb_el = now_q - ct_nx;

	// Blink interval per mode
	always_comb begin
		unique case (mode_q)
			dmlb_pkg::MODE_SLOW:   ivl = slow_q;
			dmlb_pkg::MODE_MEDIUM: ivl = med_q;
			dmlb_pkg::MODE_FAST:   ivl = fast_q;
			dmlb_pkg::MODE_ALT:    ivl = slow_q;
			default:               ivl = slow_q;
		endcase
	end

	assign blinking = (mode_q == dmlb_pkg::MODE_SLOW) || (mode_q == dmlb_pkg::MODE_MEDIUM) ||
			(mode_q == dmlb_pkg::MODE_FAST) || (mode_q == dmlb_pkg::MODE_ALT);
	assign blk_el   = now_q - blk_q;
	assign due      = blinking && (blk_el >= {16'd0, ivl});
	assign win_chk  = (mode_q == dmlb_pkg::MODE_STEADY) ||
			(due && (mode_q != dmlb_pkg::MODE_ALT));
	assign win_el   = now_q - win_q;
	assign stat.win_due  = win_chk && (win_el >= {16'd0, win_ms_q});
	assign stat.div_last = (k_q == KW'(SW - 1));

	// Restoring division step: one quotient bit per cycle
	assign trial     = {rem_q, dvd_q[SW-1]};
	assign q_bit     = (trial >= {1'b0, dvs_q});
	assign trial_sub = trial - {1'b0, dvs_q};

	// Darkness test on the mean that this step leaves
	assign mean_nx = pend_q ? MW'(dvd_q[LIGHT_BITS-1:0]) : mean_q;
	assign dark    = TW'(mean_nx) < TW'(thr_q);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ms_q <= dmlb_pkg::RST_DEBOUNCE;
			thr_q    <= dmlb_pkg::RST_DARK_THR;
			win_ms_q <= dmlb_pkg::RST_WINDOW;
			slow_q   <= dmlb_pkg::RST_SLOW;
			med_q    <= dmlb_pkg::RST_MEDIUM;
			fast_q   <= dmlb_pkg::RST_FAST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dmlb_pkg::REG_DEBOUNCE: deb_ms_q <= cfg_data;
				dmlb_pkg::REG_DARK_THR: thr_q    <= cfg_data[10:0];
				dmlb_pkg::REG_WINDOW:   win_ms_q <= cfg_data;
				dmlb_pkg::REG_SLOW:     slow_q   <= cfg_data;
				dmlb_pkg::REG_MEDIUM:   med_q    <= cfg_data;
				dmlb_pkg::REG_FAST:     fast_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the input item, run the divider and load the output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lvl_q <= button_level;
			smp_q <= light_sample;
			now_q <= now_ms;
		end
		if (cmd.blk) begin
			dvd_q <= sum_q;
			dvs_q <= cnt_q;
			rem_q <= '0;
			k_q   <= '0;
		end else if (cmd.div) begin
			rem_q <= q_bit ? trial_sub[CW-1:0] : trial[CW-1:0];
			dvd_q <= {dvd_q[SW-2:0], q_bit};
			k_q   <= k_q + KW'(1);
		end
		if (cmd.pub) begin
			o_led1_q <= pin1_q;
			o_led2_q <= pin2_q;
			o_mode_q <= mode_q;
		end
	end

	// Step the block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			stab_q  <= 1'b0;
			chg_q   <= '0;
			mode_q  <= dmlb_pkg::MODE_OFF;
			blk_q   <= '0;
			win_q   <= '0;
			phase_q <= 1'b1;
			pin1_q  <= 1'b0;
			pin2_q  <= 1'b0;
			sum_q   <= '0;
			cnt_q   <= '0;
			mean_q  <= MW'(dmlb_pkg::MEAN_RESET);
			tog_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			// append sample, debounce, step mode
			if (cmd.deb) begin
				if (cnt_q < CW'(SAMPLE_SLOTS)) begin
					sum_q <= sum_q + SW'(smp_q);
					cnt_q <= cnt_q + CW'(1);
				end
				chg_q  <= ct_nx;
				last_q <= lvl_q;
				if ((deb_el > {16'd0, deb_ms_q}) && (lvl_q != stab_q)) begin
					stab_q <= lvl_q;
					if (lvl_q)
						mode_q <= (mode_q == dmlb_pkg::MODE_MAX) ?
								dmlb_pkg::MODE_STEADY : mode_q + 3'd1;
				end
			end
			// blink toggle and window restart
			if (cmd.blk) begin
				tog_q <= due;
				if (due) begin
					blk_q   <= now_q;
					phase_q <= ~phase_q;
				end
				pend_q <= stat.win_due;
				if (stat.win_due) begin
					win_q <= now_q;
					sum_q <= '0;
					cnt_q <= '0;
				end
			end
			// mean and LED pins
			if (cmd.set) begin
				mean_q <= mean_nx;
				unique case (mode_q)
					dmlb_pkg::MODE_STEADY: begin
						pin1_q <= 1'b1;
						pin2_q <= dark;
					end
					dmlb_pkg::MODE_SLOW, dmlb_pkg::MODE_MEDIUM, dmlb_pkg::MODE_FAST: begin
						if (tog_q) begin
							pin1_q <= phase_q;
							pin2_q <= dark & phase_q;
						end
					end
					dmlb_pkg::MODE_ALT: begin
						if (tog_q) begin
							pin1_q <= phase_q;
							pin2_q <= ~phase_q;
						end
					end
					default: begin
						pin1_q <= 1'b0;
						pin2_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign led_one  = o_led1_q;
	assign led_two  = o_led2_q;
	assign mode_now = o_mode_q;

endmodule

@@ src/debounced_mode_led_blink_controller.sv @@
// Debounced mode LED blink controller.
// Input channel (in_valid/in_ready) carries one button level, one light
// sample and a millisecond timestamp per transfer; every input transfer
// yields exactly one result on the output channel (out_valid/out_ready):
// both LED levels and the mode counter after that step.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no item is in flight. Unknown indexes are dropped.
// When the light window expires, the mean is recomputed by the restoring
// divider, one quotient bit per cycle over SW iterations, where
// SW = LIGHT_BITS + clog2(SAMPLE_SLOTS+1) (13 at the defaults).
// The block works on a single item at a time and takes no new item
// before it is through with the last one.
// A finished result waits in the output register; the block still takes the
// next item and computes it, holding it until the output register frees.
// Reset (arst_n low) returns the configuration registers and block state to
// their defaults and drops any pending result.
module debounced_mode_led_blink_controller #(
	parameter int SAMPLE_SLOTS = 5,
	parameter int LIGHT_BITS   = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  button_level,
	input  logic [LIGHT_BITS-1:0] light_sample,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  led_one,
	output logic                  led_two,
	output logic [2:0]            mode_now,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	dmlb_pkg::cmd_t  cmd;
	dmlb_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	dmlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dmlb_dp #(
		.SAMPLE_SLOTS (SAMPLE_SLOTS),
		.LIGHT_BITS   (LIGHT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.button_level (button_level),
		.light_sample (light_sample),
		.now_ms       (now_ms),
		.led_one      (led_one),
		.led_two      (led_two),
		.mode_now     (mode_now)
	);

endmodule

@@ src/dmlb_chk.sv @@
module dmlb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       led_one,
	input logic       led_two,
	input logic [2:0] mode_now
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led_one) && $stable(led_two)
			&& $stable(mode_now))
		else $error("stalled result changed or dropped");

	// One item at a time: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is at work");

	// Off modes drive both LEDs low
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode_now == dmlb_pkg::MODE_OFF || mode_now > dmlb_pkg::MODE_ALT)
			|-> !led_one && !led_two)
		else $error("LED lit in an off mode");

	// Steady mode holds LED one on
	a_steady_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now == dmlb_pkg::MODE_STEADY |-> led_one)
		else $error("LED one off in steady mode");

endmodule

bind debounced_mode_led_blink_controller dmlb_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.led_one   (led_one),
	.led_two   (led_two),
	.mode_now  (mode_now)
);
